/* rtl/core/ggp_pkg.sv */
// Package with the shared types, constants and arctangent table of the go-to-goal controller.
`timescale 1ns / 1ps
`default_nettype none
package ggp_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int STEP_LIMIT       = 24;
   localparam int STEP_W           = $clog2(STEP_LIMIT);

   localparam int POS_W     = 16;
   localparam int DIFF_W    = POS_W + 1;
   localparam int HEADING_W = 15;
   localparam int GAIN_W    = 8;
   localparam int SPEED_W   = 16;
   localparam int TURN_W    = 18;

   localparam int XY_W  = 28;
   localparam int MAG_W = XY_W - 1;
   localparam int Z_W   = 20;
   localparam int ERR_W = 22;

   localparam int PI_Q16     = 205887;
   localparam int TWO_PI_Q16 = 411775;
   localparam int INV_K_Q16  = 39797;
   localparam int INV_K_W    = 16;

   localparam int LIN_GAIN_RESET = 32;
   localparam int ANG_GAIN_RESET = 96;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CSR_LINEAR_GAIN  = 1'b0,
      CSR_ANGULAR_GAIN = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_GOAL = 1'b0,
      KIND_POSE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ITER,
      BK_MUL_A,
      BK_MUL_B,
      BK_FIN
   } back_state_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0]    dx;
      logic signed [DIFF_W-1:0]    dy;
      logic signed [HEADING_W-1:0] heading;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic [15:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [15:0] val;
      case (idx)
         5'd0:    val = 16'd51472;
         5'd1:    val = 16'd30386;
         5'd2:    val = 16'd16055;
         5'd3:    val = 16'd8150;
         5'd4:    val = 16'd4091;
         5'd5:    val = 16'd2047;
         5'd6:    val = 16'd1024;
         5'd7:    val = 16'd512;
         5'd8:    val = 16'd256;
         5'd9:    val = 16'd128;
         5'd10:   val = 16'd64;
         5'd11:   val = 16'd32;
         5'd12:   val = 16'd16;
         5'd13:   val = 16'd8;
         5'd14:   val = 16'd4;
         5'd15:   val = 16'd2;
         5'd16:   val = 16'd1;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/ggp_front.sv */
// Front end: accepts beats, keeps the goal and queues goal offsets for pose beats.
`timescale 1ns / 1ps
`default_nettype none
module ggp_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_kind,
   input  wire logic signed [ggp_pkg::POS_W-1:0]     req_pos_x,
   input  wire logic signed [ggp_pkg::POS_W-1:0]     req_pos_y,
   input  wire logic signed [ggp_pkg::HEADING_W-1:0] req_heading,
   input  wire ggp_pkg::queue_stat_type              q_stat,
   output ggp_pkg::push_type                         push
);
   import ggp_pkg::*;

   logic signed [POS_W-1:0] goal_x_ff, goal_x_in;
   logic signed [POS_W-1:0] goal_y_ff, goal_y_in;
   logic                    goal_valid_ff, goal_valid_in;
   logic                    accept;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;

   always_comb begin
      goal_x_in     = goal_x_ff;
      goal_y_in     = goal_y_ff;
      goal_valid_in = goal_valid_ff;
      push.valid    = 1'b0;
      push.job.dx   = DIFF_W'(goal_x_ff) - DIFF_W'(req_pos_x);
      push.job.dy   = DIFF_W'(goal_y_ff) - DIFF_W'(req_pos_y);
      push.job.heading = req_heading;
      if (accept) begin
         if (req_kind == KIND_GOAL) begin
            goal_x_in     = req_pos_x;
            goal_y_in     = req_pos_y;
            goal_valid_in = 1'b1;
         end else begin
            push.valid = goal_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         goal_valid_ff <= 1'b0;
      end else begin
         goal_x_ff     <= goal_x_in;
         goal_y_ff     <= goal_y_in;
         goal_valid_ff <= goal_valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/ggp_queue.sv */
// Short job queue between the front end and the CORDIC back end.
`timescale 1ns / 1ps
`default_nettype none
module ggp_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ggp_pkg::push_type       push,
   input  wire logic                    pop,
   output ggp_pkg::job_type             head,
   output ggp_pkg::queue_stat_type      q_stat
);
   import ggp_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] n;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + QPTR_W'(1);
      end
      return n;
   endfunction

   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/ggp_back.sv */
// Back end: iterative vectoring CORDIC, gain multiplies, rounding and output register.
`timescale 1ns / 1ps
`default_nettype none
module ggp_back #(
   parameter int CORDIC_STEPS = ggp_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ggp_pkg::job_type                   head,
   input  wire ggp_pkg::queue_stat_type            q_stat,
   output logic                                    pop,
   input  wire logic [ggp_pkg::GAIN_W-1:0]         linear_gain,
   input  wire logic [ggp_pkg::GAIN_W-1:0]         angular_gain,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [ggp_pkg::SPEED_W-1:0]             rsp_linear_speed,
   output logic signed [ggp_pkg::TURN_W-1:0]       rsp_turn_rate
);
   import ggp_pkg::*;

   localparam int NUM_STEPS = (CORDIC_STEPS > STEP_LIMIT) ? STEP_LIMIT : CORDIC_STEPS;
   localparam int PROD1_W   = MAG_W + INV_K_W;
   localparam int PROD2_W   = PROD1_W + GAIN_W;
   localparam int TPROD_W   = ERR_W + GAIN_W + 1;
   localparam int TSUM_W    = TPROD_W + 1;
   localparam int TSH_W     = TSUM_W - 8;
   localparam int SSUM_W    = PROD2_W + 1;
   localparam int SSH_W     = SSUM_W - 28;

   back_state_type state_ff, state_in;

   logic signed [XY_W-1:0]      x_ff, x_in;
   logic signed [XY_W-1:0]      y_ff, y_in;
   logic signed [Z_W-1:0]       z_ff, z_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic signed [HEADING_W-1:0] heading_ff, heading_in;
   logic [PROD1_W-1:0]          prod1_ff, prod1_in;
   logic [PROD2_W-1:0]          prod2_ff, prod2_in;
   logic signed [ERR_W-1:0]     err_ff, err_in;
   logic signed [TPROD_W-1:0]   tprod_ff, tprod_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0]          speed_ff, speed_in;
   logic signed [TURN_W-1:0]    turn_ff, turn_in;

   logic signed [XY_W-1:0]      xs, ys, x0, y0;
   logic signed [Z_W-1:0]       atan_z;
   logic signed [ERR_W-1:0]     err_raw;
   logic signed [TSUM_W-1:0]    tsum;
   logic signed [TSH_W-1:0]     tsh;
   logic [SSUM_W-1:0]           ssum;
   logic [SSH_W-1:0]            ssh;
   logic                        out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_linear_speed = speed_ff;
   assign rsp_turn_rate    = turn_ff;
   assign out_free         = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      atan_z  = Z_W'(atan_entry(step_ff));
      x0      = XY_W'(head.dx) <<< 8;
      y0      = XY_W'(head.dy) <<< 8;
      err_raw = ERR_W'(z_ff) - (ERR_W'(heading_ff) <<< 4);
      tsum    = TSUM_W'(tprod_ff) + TSUM_W'(128);
      tsh     = TSH_W'(tsum >>> 8);
      ssum    = SSUM_W'(prod2_ff) + (SSUM_W'(1) << 27);
      ssh     = SSH_W'(ssum >> 28);

      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      step_in      = step_ff;
      heading_in   = heading_ff;
      prod1_in     = prod1_ff;
      prod2_in     = prod2_ff;
      err_in       = err_ff;
      tprod_in     = tprod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      speed_in     = speed_ff;
      turn_in      = turn_ff;
      pop          = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               pop        = 1'b1;
               heading_in = head.heading;
               step_in    = '0;
               if (head.dx == '0 && head.dy == '0) begin
                  x_in     = '0;
                  y_in     = '0;
                  z_in     = '0;
                  state_in = BK_MUL_A;
               end else begin
                  if (head.dx < 0) begin
                     x_in = -x0;
                     y_in = -y0;
                     z_in = (head.dy >= 0) ? Z_W'(PI_Q16) : -Z_W'(PI_Q16);
                  end else begin
                     x_in = x0;
                     y_in = y0;
                     z_in = '0;
                  end
                  state_in = BK_ITER;
               end
            end
         end
         BK_ITER: begin
            if (y_ff > 0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_z;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_z;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(NUM_STEPS - 1)) begin
               state_in = BK_MUL_A;
            end
         end
         BK_MUL_A: begin
            prod1_in = PROD1_W'(x_ff[MAG_W-1:0]) * PROD1_W'(INV_K_Q16);
            if (err_raw > ERR_W'(PI_Q16)) begin
               err_in = err_raw - ERR_W'(TWO_PI_Q16);
            end else if (err_raw < -ERR_W'(PI_Q16)) begin
               err_in = err_raw + ERR_W'(TWO_PI_Q16);
            end else begin
               err_in = err_raw;
            end
            state_in = BK_MUL_B;
         end
         BK_MUL_B: begin
            prod2_in = PROD2_W'(prod1_ff) * PROD2_W'(linear_gain);
            tprod_in = TPROD_W'(err_ff) * $signed({1'b0, angular_gain});
            state_in = BK_FIN;
         end
         BK_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               speed_in     = (ssh > SSH_W'(16'hFFFF)) ? '1 : SPEED_W'(ssh);
               if (tsh > TSH_W'(131071)) begin
                  turn_in = TURN_W'(131071);
               end else if (tsh < -TSH_W'(131072)) begin
                  turn_in = -TURN_W'(131072);
               end else begin
                  turn_in = TURN_W'(tsh);
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      step_ff    <= step_in;
      heading_ff <= heading_in;
      prod1_ff   <= prod1_in;
      prod2_ff   <= prod2_in;
      err_ff     <= err_in;
      tprod_ff   <= tprod_in;
      speed_ff   <= speed_in;
      turn_ff    <= turn_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/go_to_goal_p_controller_core.sv */
// Top level of the proportional go-to-goal controller with gain registers.
// A pose beat is queued, then the back end pops it, runs the CORDIC steps and the gain
// multiplies, rounds and registers the result; it works on one pose job at a time.
// Goal beats are accepted while the back end works, unless the job queue is full.
// Reset is synchronous: it clears the goal, the queue, the output and loads default gains.
`timescale 1ns / 1ps
`default_nettype none
module go_to_goal_p_controller_core #(
   parameter int CORDIC_STEPS = ggp_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_kind,
   input  wire logic signed [ggp_pkg::POS_W-1:0]     req_pos_x,
   input  wire logic signed [ggp_pkg::POS_W-1:0]     req_pos_y,
   input  wire logic signed [ggp_pkg::HEADING_W-1:0] req_heading,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [ggp_pkg::SPEED_W-1:0]               rsp_linear_speed,
   output logic signed [ggp_pkg::TURN_W-1:0]         rsp_turn_rate,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic                                 csr_index,
   input  wire logic [ggp_pkg::GAIN_W-1:0]           csr_data
);
   import ggp_pkg::*;

   logic [GAIN_W-1:0] lin_gain_ff, lin_gain_in;
   logic [GAIN_W-1:0] ang_gain_ff, ang_gain_in;
   push_type          push;
   queue_stat_type    q_stat;
   job_type           head;
   logic              pop;

   assign csr_ready = 1'b1;

   always_comb begin
      lin_gain_in = lin_gain_ff;
      ang_gain_in = ang_gain_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LINEAR_GAIN:  lin_gain_in = csr_data;
            CSR_ANGULAR_GAIN: ang_gain_in = csr_data;
            default: begin
               lin_gain_in = lin_gain_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_gain_ff <= GAIN_W'(LIN_GAIN_RESET);
         ang_gain_ff <= GAIN_W'(ANG_GAIN_RESET);
      end else begin
         lin_gain_ff <= lin_gain_in;
         ang_gain_ff <= ang_gain_in;
      end
   end

   ggp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_heading (req_heading),
      .q_stat      (q_stat),
      .push        (push)
   );

   ggp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   ggp_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_stat           (q_stat),
      .pop              (pop),
      .linear_gain      (lin_gain_ff),
      .angular_gain     (ang_gain_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_turn_rate    (rsp_turn_rate)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_stat.full)
      else $error("Job queue written while full.");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("Job queue read while empty.");

   a_goal_beat_no_job: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == KIND_GOAL) |-> !push.valid)
      else $error("Goal beat produced a job.");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat valid right after reset.");

endmodule
`default_nettype wire

/* bench/go_to_goal_p_controller_core_test.sv */
// Self-checking testbench of the go-to-goal controller core: directed table, gain sweeps, random beats.
`timescale 1ns / 1ps
module go_to_goal_p_controller_core_test;
   import ggp_pkg::*;

   localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
   localparam int SETTLE_CYCLES = CORDIC_STEPS + 20;
   localparam int BEATS_PER_PHASE = 150;
   localparam int PHASES = 8;
   localparam int HEADING_PI = 12868;

   typedef enum logic [1:0] {
      ROW_PREDICTED,
      ROW_TYPED,
      ROW_SILENT
   } row_check_type;

   typedef struct {
      row_check_type               check;
      kind_type                    kind;
      logic signed [POS_W-1:0]     pos_x;
      logic signed [POS_W-1:0]     pos_y;
      logic signed [HEADING_W-1:0] heading;
      logic [SPEED_W-1:0]          speed;
      logic signed [TURN_W-1:0]    turn;
   } plan_row_type;

   typedef struct {
      logic [SPEED_W-1:0]       speed;
      logic signed [TURN_W-1:0] turn;
   } command_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_kind;
   logic signed [POS_W-1:0]     req_pos_x;
   logic signed [POS_W-1:0]     req_pos_y;
   logic signed [HEADING_W-1:0] req_heading;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [SPEED_W-1:0]          rsp_linear_speed;
   logic signed [TURN_W-1:0]    rsp_turn_rate;
   logic                        csr_valid;
   logic                        csr_ready;
   logic                        csr_index;
   logic [GAIN_W-1:0]           csr_data;

   logic [GAIN_W-1:0]       lin_gain;
   logic [GAIN_W-1:0]       ang_gain;
   logic signed [POS_W-1:0] goal_x;
   logic signed [POS_W-1:0] goal_y;
   logic                    goal_set;
   command_type             pending_commands [$];
   plan_row_type            plan [$];
   int                      errors;
   bit                      steady;

   longint arc_tab [0:STEP_LIMIT-1] = '{
      51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2,
      1, 0, 0, 0, 0, 0, 0, 0
   };

   go_to_goal_p_controller_core #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_heading(req_heading),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_linear_speed(rsp_linear_speed),
      .rsp_turn_rate(rsp_turn_rate),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic flag_error(input string what);
      errors = errors + 1;
      if (errors <= 50) $display("ERROR at %0t: %s", $time, what);
   endtask

   function automatic command_type steer_command(input logic signed [POS_W-1:0] px,
                                                 input logic signed [POS_W-1:0] py,
                                                 input logic signed [HEADING_W-1:0] hd);
      longint      dx, dy, vx, vy, ang, sx, sy, err, turn, speed;
      int          steps, i;
      command_type cmd;
      dx = longint'(goal_x) - longint'(px);
      dy = longint'(goal_y) - longint'(py);
      vx = dx * 256;
      vy = dy * 256;
      ang = 0;
      steps = (CORDIC_STEPS > STEP_LIMIT) ? STEP_LIMIT : CORDIC_STEPS;
      if (dx != 0 || dy != 0) begin
         if (dx < 0) begin
            vx = -vx;
            vy = -vy;
            ang = (dy >= 0) ? PI_Q16 : -PI_Q16;
         end
         for (i = 0; i < steps; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy > 0) begin
               vx = vx + sy;
               vy = vy - sx;
               ang = ang + arc_tab[i];
            end else begin
               vx = vx - sy;
               vy = vy + sx;
               ang = ang - arc_tab[i];
            end
         end
      end else begin
         vx = 0;
      end
      speed = (vx * INV_K_Q16 * longint'(lin_gain) + 64'sd134217728) >>> 28;
      if (speed > 65535) speed = 65535;
      err = ang - longint'(hd) * 16;
      if (err > PI_Q16) err = err - TWO_PI_Q16;
      else if (err < -PI_Q16) err = err + TWO_PI_Q16;
      turn = (err * longint'(ang_gain) + 128) >>> 8;
      if (turn > 131071) turn = 131071;
      else if (turn < -131072) turn = -131072;
      cmd.speed = speed[SPEED_W-1:0];
      cmd.turn = turn[TURN_W-1:0];
      return cmd;
   endfunction

   task automatic add_row(input row_check_type check, input kind_type k, input int x,
                          input int y, input int hd, input int spd, input int trn);
      plan_row_type row;
      row.check = check;
      row.kind = k;
      row.pos_x = POS_W'(x);
      row.pos_y = POS_W'(y);
      row.heading = HEADING_W'(hd);
      row.speed = SPEED_W'(spd);
      row.turn = TURN_W'(trn);
      plan.push_back(row);
   endtask

   task automatic send_beat(input kind_type k, input logic signed [POS_W-1:0] x,
                            input logic signed [POS_W-1:0] y,
                            input logic signed [HEADING_W-1:0] hd);
      req_valid <= 1'b1;
      req_kind <= k;
      req_pos_x <= x;
      req_pos_y <= y;
      req_heading <= hd;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic take_beat(input kind_type k, input logic signed [POS_W-1:0] x,
                            input logic signed [POS_W-1:0] y,
                            input logic signed [HEADING_W-1:0] hd, input row_check_type check,
                            input logic [SPEED_W-1:0] spd, input logic signed [TURN_W-1:0] trn);
      command_type typed;
      typed.speed = spd;
      typed.turn = trn;
      if (k == KIND_GOAL) begin
         goal_x = x;
         goal_y = y;
         goal_set = 1'b1;
      end else if (check == ROW_TYPED) begin
         pending_commands.push_back(typed);
      end else if (check == ROW_PREDICTED && goal_set) begin
         pending_commands.push_back(steer_command(x, y, hd));
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic pause_sender();
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_gains(input logic [GAIN_W-1:0] lin, input logic [GAIN_W-1:0] ang);
      csr_valid <= 1'b1;
      csr_index <= CSR_LINEAR_GAIN;
      csr_data <= lin;
      do @(posedge clock); while (!csr_ready);
      lin_gain = lin;
      csr_index <= CSR_ANGULAR_GAIN;
      csr_data <= ang;
      do @(posedge clock); while (!csr_ready);
      ang_gain = ang;
      csr_valid <= 1'b0;
   endtask

   task automatic random_beat();
      kind_type                    k;
      logic signed [POS_W-1:0]     x, y;
      logic signed [HEADING_W-1:0] hd;
      int                          r;
      r = $urandom_range(0, 99);
      k = (r < 12) ? KIND_GOAL : KIND_POSE;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         x = POS_W'($urandom);
         y = POS_W'($urandom);
      end else if (r < 80) begin
         x = POS_W'(int'(goal_x) + int'($urandom_range(0, 1023)) - 512);
         y = POS_W'(int'(goal_y) + int'($urandom_range(0, 1023)) - 512);
      end else if (r < 90) begin
         x = goal_x;
         y = goal_y;
      end else if (r < 95) begin
         x = goal_x;
         y = POS_W'($urandom);
      end else begin
         x = POS_W'($urandom);
         y = goal_y;
      end
      if ($urandom_range(0, 99) < 85)
         hd = HEADING_W'(int'($urandom_range(0, 2 * HEADING_PI)) - HEADING_PI);
      else hd = HEADING_W'($urandom);
      send_beat(k, x, y, hd);
      take_beat(k, x, y, hd, ROW_PREDICTED, '0, '0);
      pause_sender();
   endtask

   initial begin : result_side
      int          hold;
      command_type want;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_commands.size() == 0) begin
               flag_error($sformatf("unexpected result beat: speed %0d turn %0d",
                                    rsp_linear_speed, rsp_turn_rate));
            end else begin
               want = pending_commands.pop_front();
               if (rsp_linear_speed !== want.speed)
                  flag_error($sformatf("linear_speed %0d, expected %0d",
                                       rsp_linear_speed, want.speed));
               if (rsp_turn_rate !== want.turn)
                  flag_error($sformatf("turn_rate %0d, expected %0d",
                                       rsp_turn_rate, want.turn));
            end
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold = hold - 1;
         end else begin
            rsp_stall <= 1'b0;
            if (!steady && $urandom_range(0, 99) < 25) hold = pick_gap();
         end
      end
   end

   initial begin
      int                phase, n;
      logic [GAIN_W-1:0] lin, ang;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_GOAL;
      req_pos_x = '0;
      req_pos_y = '0;
      req_heading = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_LINEAR_GAIN;
      csr_data = '0;
      errors = 0;
      steady = 1'b0;
      lin_gain = GAIN_W'(LIN_GAIN_RESET);
      ang_gain = GAIN_W'(ANG_GAIN_RESET);
      goal_x = '0;
      goal_y = '0;
      goal_set = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Poses that arrive before any goal must be dropped without a result.
      add_row(ROW_SILENT, KIND_POSE, 100, 200, 0, 0, 0);
      add_row(ROW_SILENT, KIND_POSE, -32768, 32767, -16384, 0, 0);
      add_row(ROW_SILENT, KIND_GOAL, 0, 0, 16383, 0, 0);
      add_row(ROW_TYPED, KIND_POSE, 0, 0, 0, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 0, 0, 12868, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 0, 0, -12868, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 0, 0, 16383, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 0, 0, -16384, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 0, -256, 0, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 256, 0, 0, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, -256, 0, 0, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 0, 256, 0, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 300, 200, 5000, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 300, -200, -5000, 0, 0);
      add_row(ROW_SILENT, KIND_GOAL, 32767, 32767, -16384, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, -32768, -32768, 12868, 0, 0);
      add_row(ROW_TYPED, KIND_POSE, 32767, 32767, 0, 0, 0);
      add_row(ROW_SILENT, KIND_GOAL, -32768, -32768, 0, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 32767, 32767, -12868, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, 32767, -32768, 0, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, -32768, 32767, 16383, 0, 0);
      add_row(ROW_SILENT, KIND_GOAL, 32767, -32768, 0, 0, 0);
      add_row(ROW_PREDICTED, KIND_POSE, -32768, 32767, 0, 0, 0);
      add_row(ROW_TYPED, KIND_POSE, 32767, -32768, 0, 0, 0);

      foreach (plan[i]) begin
         send_beat(plan[i].kind, plan[i].pos_x, plan[i].pos_y, plan[i].heading);
         take_beat(plan[i].kind, plan[i].pos_x, plan[i].pos_y, plan[i].heading,
                   plan[i].check, plan[i].speed, plan[i].turn);
         pause_sender();
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin lin = 8'd0; ang = 8'd255; end
            1: begin lin = 8'd255; ang = 8'd0; end
            2: begin lin = 8'd255; ang = 8'd255; end
            3: begin lin = 8'd0; ang = 8'd0; end
            4: begin lin = 8'd32; ang = 8'd96; end
            default: begin
               lin = GAIN_W'($urandom_range(0, 255));
               ang = GAIN_W'($urandom_range(0, 255));
            end
         endcase
         steady = (phase == 4);
         load_gains(lin, ang);
         for (n = 0; n < BEATS_PER_PHASE; n++) begin
            // Halfway through, the sender holds off until every result beat is back.
            if (n == BEATS_PER_PHASE / 2) wait_idle();
            random_beat();
         end
      end

      steady = 1'b0;
      wait_idle();
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
